// ===== design/dtsi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsi_pkg
// Shared types and constants for the decimal text to scaled int128 core.
// ----------------------------------------------------------------------------
package dtsi_pkg;

    localparam int MAX_SCALE     = 38;
    localparam int FIFO_DEPTH    = 4;
    localparam int SCALE_W       = 6;
    localparam int ACC_W         = 128;
    localparam int STATUS_W      = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    typedef enum logic [2:0] {
        KIND_DIGIT,
        KIND_POINT,
        KIND_PLUS,
        KIND_MINUS,
        KIND_OTHER
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MALFORMED = 2'd1,
        STATUS_SCALE     = 2'd2
    } status_t;

    typedef struct packed {
        logic       byte_valid;
        logic       last;
        kind_t      kind;
        logic [3:0] digit;
    } item_t;

endpackage
`default_nettype wire

// ===== design/decimal_text_to_scaled_int128_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_int128_core
// Parses decimal text, one byte per request, into a scaled signed 128-bit value.
// ----------------------------------------------------------------------------
// A field arrives one byte per request and is folded into the accumulator at
// one byte per cycle while the parser is accumulating and the queue is not
// empty; a small queue in front of the parser keeps taking bytes while a field
// is being finished. At the last byte of a field the back end checks the text,
// multiplies by ten once per missing fraction digit (fraction_scale minus the
// fraction digits kept), applies the sign and loads the output register, which
// waits for m_tready if it still holds a result; a rejected or empty field
// goes from the check straight to the output register. The result gives the
// 128-bit two's complement value in m_tdata and the status in m_tuser; the
// value is zero whenever the status is not ok. Configuration must be written
// only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module decimal_text_to_scaled_int128_core #(
    parameter int FIFO_DEPTH = dtsi_pkg::FIFO_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // char_byte
    input  wire logic                           s_tuser,   // byte_valid
    input  wire logic                           s_tlast,   // field_end
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [dtsi_pkg::ACC_W-1:0]          m_tdata,   // value_low, value_high
    output logic [dtsi_pkg::STATUS_W-1:0]       m_tuser,   // status
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [dtsi_pkg::SCALE_W-1:0]   cfg_data
);
    import dtsi_pkg::*;

    localparam logic CFG_FRACTION_SCALE = 1'b0;
    localparam logic CFG_EXACT_FRAC     = 1'b1;

    logic [SCALE_W-1:0] fraction_scale_reg;
    logic               exact_frac_reg;
    logic               q_full;
    logic               q_push;
    item_t              q_item;
    logic               q_pop;
    item_t              q_head;
    logic               q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_scale_reg <= '0;
            exact_frac_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRACTION_SCALE: fraction_scale_reg <= cfg_data;
                CFG_EXACT_FRAC:     exact_frac_reg     <= cfg_data[0];
                default:            exact_frac_reg     <= exact_frac_reg;
            endcase
        end
    end

    dtsi_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    dtsi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    dtsi_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fraction_scale (fraction_scale_reg),
        .exact_frac     (exact_frac_reg),
        .head           (q_head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule
`default_nettype wire

// ===== design/dtsi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsi_front
// Input stage: takes one byte per request, classifies it, pushes the queue.
// ----------------------------------------------------------------------------
module dtsi_front (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // char_byte
    input  wire logic          s_tuser,   // byte_valid
    input  wire logic          s_tlast,   // field_end
    input  wire logic          q_full,
    output logic               q_push,
    output dtsi_pkg::item_t    q_item
);
    import dtsi_pkg::*;

    logic       is_digit;
    logic [7:0] digit_full;

    assign s_tready   = ~q_full;
    assign q_push     = s_tvalid & ~q_full;
    assign is_digit   = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit_full = s_tdata - CHAR_ZERO;

    always_comb
    begin
        q_item.byte_valid = s_tuser;
        q_item.last       = s_tlast;
        q_item.digit      = digit_full[3:0];
        if (is_digit)
        begin
            q_item.kind = KIND_DIGIT;
        end
        else if (s_tdata == CHAR_POINT)
        begin
            q_item.kind = KIND_POINT;
        end
        else if (s_tdata == CHAR_PLUS)
        begin
            q_item.kind = KIND_PLUS;
        end
        else if (s_tdata == CHAR_MINUS)
        begin
            q_item.kind = KIND_MINUS;
        end
        else
        begin
            q_item.kind = KIND_OTHER;
        end
    end

endmodule
`default_nettype wire

// ===== design/dtsi_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsi_fifo
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module dtsi_fifo #(
    parameter int DEPTH = dtsi_pkg::FIFO_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  dtsi_pkg::item_t    push_item,
    output logic               full,
    input  wire logic          pop,
    output dtsi_pkg::item_t    head,
    output logic               empty
);
    import dtsi_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/dtsi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsi_back
// Parser and accumulator: folds digits, pads to scale, negates, emits result.
// ----------------------------------------------------------------------------
module dtsi_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [dtsi_pkg::SCALE_W-1:0]     fraction_scale,
    input  wire logic                             exact_frac,
    input  dtsi_pkg::item_t                       head,
    input  wire logic                             q_empty,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [dtsi_pkg::ACC_W-1:0]            m_tdata,
    output logic [dtsi_pkg::STATUS_W-1:0]         m_tuser
);
    import dtsi_pkg::*;

    localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(MAX_SCALE);
    localparam logic [SCALE_W-1:0] SEEN_MAX  = SCALE_W'(MAX_SCALE + 1);

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_BAD
    } phase_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_CHECK,
        ST_PAD,
        ST_NEG,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      acc_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic                  sign_reg;
    logic                  sign_next;
    logic                  any_reg;
    logic                  any_next;
    logic [SCALE_W-1:0]    kept_reg;
    logic [SCALE_W-1:0]    kept_next;
    logic [SCALE_W-1:0]    seen_reg;
    logic [SCALE_W-1:0]    seen_next;
    status_t               status_reg;
    status_t               status_chk;
    logic                  out_valid_reg;
    logic [ACC_W-1:0]      out_data_reg;
    status_t               out_status_reg;
    logic                  out_free;
    logic [ACC_W-1:0]      acc_digit;

    function automatic logic [ACC_W-1:0] times_ten_plus(
        input logic [ACC_W-1:0] a,
        input logic [3:0]       d
    );
        logic [ACC_W-1:0] r;
        r = {a[ACC_W-4:0], 3'b000} + {a[ACC_W-2:0], 1'b0}
            + {{(ACC_W-4){1'b0}}, d};
        return r;
    endfunction

    assign q_pop     = (state_reg == ST_ACCUM) && !q_empty;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_status_reg;
    assign acc_digit = times_ten_plus(acc_reg, head.digit);

    // one byte through the grammar
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        sign_next  = sign_reg;
        any_next   = any_reg;
        kept_next  = kept_reg;
        seen_next  = seen_reg;
        if (head.byte_valid && phase_reg != PH_BAD)
        begin
            if (phase_reg == PH_START
                && (head.kind == KIND_PLUS || head.kind == KIND_MINUS))
            begin
                phase_next = PH_INT;
                sign_next  = 1'b1;
                neg_next   = (head.kind == KIND_MINUS);
            end
            else if (phase_reg == PH_START || phase_reg == PH_INT)
            begin
                if (head.kind == KIND_DIGIT)
                begin
                    phase_next = PH_INT;
                    acc_next   = acc_digit;
                    any_next   = 1'b1;
                end
                else if (head.kind == KIND_POINT)
                begin
                    phase_next = PH_FRAC;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            else
            begin
                if (head.kind == KIND_DIGIT)
                begin
                    any_next = 1'b1;
                    if (kept_reg < fraction_scale)
                    begin
                        acc_next  = acc_digit;
                        kept_next = kept_reg + 1'b1;
                    end
                    if (seen_reg < SEEN_MAX)
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
        end
    end

    always_comb
    begin
        if (phase_reg == PH_START)
        begin
            status_chk = STATUS_OK;
        end
        else if (fraction_scale > SCALE_MAX || phase_reg == PH_BAD
                 || (sign_reg && !any_reg))
        begin
            status_chk = STATUS_MALFORMED;
        end
        else if (exact_frac && seen_reg > fraction_scale)
        begin
            status_chk = STATUS_SCALE;
        end
        else
        begin
            status_chk = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACCUM;
            phase_reg      <= PH_START;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            sign_reg       <= 1'b0;
            any_reg        <= 1'b0;
            kept_reg       <= '0;
            seen_reg       <= '0;
            status_reg     <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_ACCUM:
                begin
                    if (!q_empty)
                    begin
                        phase_reg <= phase_next;
                        acc_reg   <= acc_next;
                        neg_reg   <= neg_next;
                        sign_reg  <= sign_next;
                        any_reg   <= any_next;
                        kept_reg  <= kept_next;
                        seen_reg  <= seen_next;
                        if (head.last)
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK:
                begin
                    status_reg <= status_chk;
                    if (status_chk == STATUS_OK && phase_reg != PH_START)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_PAD:
                begin
                    if (kept_reg == fraction_scale)
                    begin
                        state_reg <= ST_NEG;
                    end
                    else
                    begin
                        acc_reg  <= times_ten_plus(acc_reg, 4'd0);
                        kept_reg <= kept_reg + 1'b1;
                    end
                end
                ST_NEG:
                begin
                    if (neg_reg)
                    begin
                        acc_reg <= ~acc_reg + 1'b1;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_data_reg   <= (status_reg == STATUS_OK) ? acc_reg : '0;
                        out_status_reg <= status_reg;
                        phase_reg      <= PH_START;
                        acc_reg        <= '0;
                        neg_reg        <= 1'b0;
                        sign_reg       <= 1'b0;
                        any_reg        <= 1'b0;
                        kept_reg       <= '0;
                        seen_reg       <= '0;
                        state_reg      <= ST_ACCUM;
                    end
                end
                default:
                begin
                    state_reg <= ST_ACCUM;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
